// ----- rtl/core/vrtr_pkg.sv -----
// ----------------------------------------------------------------------------
// vrtr_pkg
// Types, field widths and codes shared by the resampler modules.
// ----------------------------------------------------------------------------
package vrtr_pkg;

    localparam int COEF_W = 18;
    localparam int P_W    = 21;
    localparam int PROD_W = COEF_W + P_W;
    localparam int X_W    = 42;
    localparam int BASE_W = X_W - 24;
    localparam int WT_W   = 17;
    localparam int WIJ_W  = 2 * WT_W;
    localparam int WF_W   = 49;
    localparam int ACC_W  = 64;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [2:0] CFG_N_COLS       = 3'd0;
    localparam logic [2:0] CFG_N_ROWS       = 3'd1;
    localparam logic [2:0] CFG_N_SLICES     = 3'd2;
    localparam logic [2:0] CFG_MATRIX_ROW_A = 3'd3;
    localparam logic [2:0] CFG_MATRIX_ROW_B = 3'd4;
    localparam logic [2:0] CFG_MATRIX_ROW_C = 3'd5;
    localparam logic [2:0] CFG_CENTER       = 3'd6;
    localparam logic [2:0] CFG_SHIFT        = 3'd7;

    localparam logic [53:0] ROW_A_RESET = 54'd65536;
    localparam logic [53:0] ROW_B_RESET = 54'd65536 << 18;
    localparam logic [53:0] ROW_C_RESET = 54'd65536 << 36;

    typedef struct packed {
        logic [2:0][53:0] mrow;
        logic [53:0]      center;
        logic [53:0]      shift;
    } xcfg_t;

    typedef struct packed {
        logic        action;
        logic [17:0] voxel_address;
        logic [15:0] voxel_value;
    } ld_t;

    typedef struct packed {
        ld_t                         ld;
        logic [2:0][BASE_W-1:0]      base;
        logic [2:0][WT_W-1:0]        w;
    } geo_t;

    typedef struct packed {
        logic                   inr;
        logic [7:0][15:0]       vox;
        logic [3:0][WIJ_W-1:0]  wij;
        logic [WT_W-1:0]        ws;
    } bl_t;

    function automatic logic signed [COEF_W-1:0] field18(input logic [53:0] word,
                                                         input int pos);
        return $signed(word[18*pos +: 18]);
    endfunction

endpackage

// ----- rtl/core/vrtr_item_if.sv -----
// ----------------------------------------------------------------------------
// vrtr_item_if
// Input channel: voxel loads and output voxel queries.
// ----------------------------------------------------------------------------
interface vrtr_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [17:0] voxel_address;
    logic [15:0] voxel_value;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic [5:0]  out_slice;

    modport source (output valid, action, voxel_address, voxel_value,
                    out_row, out_col, out_slice, input ready);
    modport sink   (input valid, action, voxel_address, voxel_value,
                    out_row, out_col, out_slice, output ready);
endinterface

// ----- rtl/core/vrtr_result_if.sv -----
// ----------------------------------------------------------------------------
// vrtr_result_if
// Output channel: one interpolated voxel per query.
// ----------------------------------------------------------------------------
interface vrtr_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_value;
    logic        in_range;

    modport source (output valid, out_value, in_range, input ready);
    modport sink   (input valid, out_value, in_range, output ready);
endinterface

// ----- rtl/core/vrtr_ram.sv -----
// ----------------------------------------------------------------------------
// vrtr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrtr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/vrtr_xform.sv -----
// ----------------------------------------------------------------------------
// vrtr_xform
// Four-stage transform: input capture, offset point, matrix products, sum and floor.
// ----------------------------------------------------------------------------
module vrtr_xform import vrtr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    vrtr_item_if.sink   item,
    input  xcfg_t       cfg,
    output logic        geo_valid,
    output geo_t        geo,
    input  logic        geo_ready
);

    logic                    a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic                    adv_a, adv_b, adv_c, adv_d;
    ld_t                     a_ld_reg, b_ld_reg, c_ld_reg;
    logic [2:0][5:0]         a_idx_reg;
    logic signed [P_W-1:0]   p_next [3];
    logic signed [P_W-1:0]   b_p_reg [3];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [PROD_W-1:0] c_prod_reg [9];
    logic signed [X_W-1:0]   x_sum [3];
    logic signed [X_W-1:0]   t_val [3];
    geo_t                    geo_next;
    geo_t                    d_geo_reg;

    assign adv_d = !d_v_reg || geo_ready;
    assign adv_c = !c_v_reg || adv_d;
    assign adv_b = !b_v_reg || adv_c;
    assign adv_a = !a_v_reg || adv_b;
    assign item.ready = adv_a;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            p_next[c] = P_W'($signed({7'd0, a_idx_reg[c], 8'd0}))
                      - P_W'(field18(cfg.center, c))
                      + P_W'(9'sd128)
                      - P_W'(field18(cfg.shift, c));
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[3*r+c] = PROD_W'(field18(cfg.mrow[r], c)) * PROD_W'(b_p_reg[c]);
            end
        end
        geo_next.ld = c_ld_reg;
        for (int r = 0; r < 3; r++)
        begin
            x_sum[r] = (X_W'(field18(cfg.center, r)) <<< 16)
                     + X_W'(c_prod_reg[3*r]) + X_W'(c_prod_reg[3*r+1])
                     + X_W'(c_prod_reg[3*r+2]);
            t_val[r] = x_sum[r] - X_W'(25'sh0800000);
            geo_next.base[r] = t_val[r][X_W-1:24];
            geo_next.w[r]    = WT_W'((25'(t_val[r][23:0]) + 25'd128) >> 8);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_a) a_v_reg <= item.valid;
            if (adv_b) b_v_reg <= a_v_reg;
            if (adv_c) c_v_reg <= b_v_reg;
            if (adv_d) d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && item.valid)
        begin
            a_ld_reg     <= '{action: item.action, voxel_address: item.voxel_address,
                              voxel_value: item.voxel_value};
            a_idx_reg[0] <= item.out_row;
            a_idx_reg[1] <= item.out_col;
            a_idx_reg[2] <= item.out_slice;
        end
        if (adv_b && a_v_reg)
        begin
            b_ld_reg <= a_ld_reg;
            for (int c = 0; c < 3; c++)
            begin
                b_p_reg[c] <= p_next[c];
            end
        end
        if (adv_c && b_v_reg)
        begin
            c_ld_reg <= b_ld_reg;
            for (int n = 0; n < 9; n++)
            begin
                c_prod_reg[n] <= prod_next[n];
            end
        end
        if (adv_d && c_v_reg)
        begin
            d_geo_reg <= geo_next;
        end
    end

    assign geo_valid = d_v_reg;
    assign geo       = d_geo_reg;

endmodule

// ----- rtl/core/vrtr_fetch.sv -----
// ----------------------------------------------------------------------------
// vrtr_fetch
// Range check, neighbour addressing and volume store access.
// ----------------------------------------------------------------------------
module vrtr_fetch import vrtr_pkg::*; #(
    parameter int VOXELS   = 262144,
    parameter int MAX_SIDE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            geo_valid,
    input  geo_t                            geo,
    output logic                            geo_ready,
    input  logic [$clog2(MAX_SIDE+1)-1:0]   cols,
    input  logic [$clog2(MAX_SIDE+1)-1:0]   rows,
    input  logic [$clog2(MAX_SIDE+1)-1:0]   slcs,
    input  logic [2*$clog2(MAX_SIDE+1)-1:0] plane,
    output logic                            bl_valid,
    output bl_t                             bl,
    input  logic                            bl_ready
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(VOXELS);
    localparam int LW = (3 * SW + 2 > AW + 1) ? 3 * SW + 2 : AW + 1;

    logic                   e_v_reg, f_v_reg, adv_e, adv_f;
    ld_t                    e_ld_reg;
    logic                   e_inr_reg, f_inr_reg;
    logic [LW-1:0]          e_addr_reg;
    logic [2:0][WT_W-1:0]   e_w_reg;
    logic                   inr_next;
    logic [LW-1:0]          addr_next;
    logic [2:0]             axis_ok;
    logic [2:0][SW-1:0]     sides;
    logic [LW-1:0]          nb_addr [8];
    logic [7:0]             ok_next, f_ok_reg;
    logic [WT_W-1:0]        w0 [3];
    logic [3:0][WIJ_W-1:0]  wij_next, f_wij_reg;
    logic [WT_W-1:0]        f_ws_reg;
    logic [15:0]            rdata [8];
    logic                   we;

    assign adv_f     = !f_v_reg || bl_ready;
    assign adv_e     = !e_v_reg || adv_f;
    assign geo_ready = adv_e;

    assign sides[0] = rows;
    assign sides[1] = cols;
    assign sides[2] = slcs;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            axis_ok[r] = !geo.base[r][BASE_W-1]
                       && (geo.base[r][BASE_W-2:0] < (BASE_W-1)'(sides[r] - 1'b1));
        end
        inr_next  = &axis_ok;
        addr_next = LW'(geo.base[1][SW-1:0])
                  + LW'(cols) * LW'(geo.base[0][SW-1:0])
                  + LW'(plane) * LW'(geo.base[2][SW-1:0]);
        for (int r = 0; r < 3; r++)
        begin
            w0[r] = WT_W'(17'd65536) - e_w_reg[r];
        end
        for (int n = 0; n < 8; n++)
        begin
            nb_addr[n] = e_addr_reg + LW'(n[1])
                       + (n[0] ? LW'(cols) : LW'(0))
                       + (n[2] ? LW'(plane) : LW'(0));
            ok_next[n] = 32'(nb_addr[n]) < 32'(VOXELS);
        end
        for (int m = 0; m < 4; m++)
        begin
            wij_next[m] = WIJ_W'(m[0] ? e_w_reg[0] : w0[0])
                        * WIJ_W'(m[1] ? e_w_reg[1] : w0[1]);
        end
    end

    assign we = e_v_reg && (e_ld_reg.action == ACT_LOAD) && adv_f
             && (32'(e_ld_reg.voxel_address) < 32'(VOXELS));

    for (genvar n = 0; n < 8; n++)
    begin : g_bank
        vrtr_ram #(
            .WIDTH (16),
            .DEPTH (VOXELS)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (AW'(e_ld_reg.voxel_address)),
            .wdata (e_ld_reg.voxel_value),
            .re    (adv_f),
            .raddr (nb_addr[n][AW-1:0]),
            .rdata (rdata[n])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_e) e_v_reg <= geo_valid;
            if (adv_f) f_v_reg <= e_v_reg && (e_ld_reg.action == ACT_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_e && geo_valid)
        begin
            e_ld_reg   <= geo.ld;
            e_inr_reg  <= inr_next;
            e_addr_reg <= addr_next;
            e_w_reg    <= geo.w;
        end
        if (adv_f && e_v_reg)
        begin
            f_inr_reg <= e_inr_reg;
            f_ok_reg  <= ok_next;
            f_wij_reg <= wij_next;
            f_ws_reg  <= e_w_reg[2];
        end
    end

    always_comb
    begin
        bl.inr = f_inr_reg;
        bl.wij = f_wij_reg;
        bl.ws  = f_ws_reg;
        for (int n = 0; n < 8; n++)
        begin
            bl.vox[n] = f_ok_reg[n] ? rdata[n] : 16'd0;
        end
    end

    assign bl_valid = f_v_reg;

endmodule

// ----- rtl/core/vrtr_blend.sv -----
// ----------------------------------------------------------------------------
// vrtr_blend
// Trilinear weights, weighted voxels, sum tree, rounding and saturation.
// ----------------------------------------------------------------------------
module vrtr_blend import vrtr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          bl_valid,
    input  bl_t           bl,
    output logic          bl_ready,
    vrtr_result_if.source result
);

    logic                  g_v_reg, h_v_reg, i_v_reg, j_v_reg;
    logic                  adv_g, adv_h, adv_i, adv_j;
    logic                  g_inr_reg, h_inr_reg, i_inr_reg;
    logic [7:0][15:0]      g_vox_reg;
    logic [WT_W-1:0]       ws0;
    logic [WF_W-1:0]       wf_next [8];
    logic [WF_W-1:0]       g_wf_reg [8];
    logic [ACC_W-1:0]      h_prod_reg [8];
    logic [ACC_W-1:0]      i_sum_reg [4];
    logic [ACC_W:0]        total;
    logic [16:0]           rounded;
    logic [15:0]           value_next, j_value_reg;
    logic                  j_inr_reg;

    assign adv_j    = !j_v_reg || result.ready;
    assign adv_i    = !i_v_reg || adv_j;
    assign adv_h    = !h_v_reg || adv_i;
    assign adv_g    = !g_v_reg || adv_h;
    assign bl_ready = adv_g;

    always_comb
    begin
        ws0 = WT_W'(17'd65536) - bl.ws;
        for (int n = 0; n < 8; n++)
        begin
            wf_next[n] = WF_W'(bl.wij[n % 4]) * WF_W'(n[2] ? bl.ws : ws0);
        end
        total = (ACC_W+1)'(i_sum_reg[0]) + (ACC_W+1)'(i_sum_reg[1])
              + (ACC_W+1)'(i_sum_reg[2]) + (ACC_W+1)'(i_sum_reg[3])
              + (ACC_W+1)'(48'h8000_0000_0000);
        rounded = total[ACC_W:48];
        if (!i_inr_reg)
        begin
            value_next = 16'd0;
        end
        else if (rounded[16])
        begin
            value_next = 16'hFFFF;
        end
        else
        begin
            value_next = rounded[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_g) g_v_reg <= bl_valid;
            if (adv_h) h_v_reg <= g_v_reg;
            if (adv_i) i_v_reg <= h_v_reg;
            if (adv_j) j_v_reg <= i_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_g && bl_valid)
        begin
            g_inr_reg <= bl.inr;
            g_vox_reg <= bl.vox;
            for (int n = 0; n < 8; n++)
            begin
                g_wf_reg[n] <= wf_next[n];
            end
        end
        if (adv_h && g_v_reg)
        begin
            h_inr_reg <= g_inr_reg;
            for (int n = 0; n < 8; n++)
            begin
                h_prod_reg[n] <= ACC_W'(ACC_W'(g_vox_reg[n]) * ACC_W'(g_wf_reg[n]));
            end
        end
        if (adv_i && h_v_reg)
        begin
            i_inr_reg <= h_inr_reg;
            for (int m = 0; m < 4; m++)
            begin
                i_sum_reg[m] <= h_prod_reg[2*m] + h_prod_reg[2*m+1];
            end
        end
        if (adv_j && i_v_reg)
        begin
            j_value_reg <= value_next;
            j_inr_reg   <= i_inr_reg;
        end
    end

    assign result.valid     = j_v_reg;
    assign result.out_value = j_value_reg;
    assign result.in_range  = j_inr_reg;

endmodule

// ----- rtl/core/volume_rigid_trilinear_resample.sv -----
// ----------------------------------------------------------------------------
// volume_rigid_trilinear_resample
// Rigid-transform trilinear resampler over a stored 3D volume.
//
//   channel   direction  contents
//   item      in         action, voxel_address, voxel_value, out_row/col/slice
//   result    out        out_value, in_range (one per query, none per load)
//   cfg       in         cfg_we, cfg_index, cfg_data
//
// One transaction per cycle in each direction while result is not stalled; a
// query result passes through the ten register stages of the path.
// Eight store replicas, one per cell corner, each give one read per cycle unless stalled.
// Reset clears pipeline valids and configuration; the store is not cleared.
// A stall on result holds full stages and lets empty ones fill.
// ----------------------------------------------------------------------------
module volume_rigid_trilinear_resample import vrtr_pkg::*; #(
    parameter int VOXELS   = 262144,
    parameter int MAX_SIDE = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    vrtr_item_if.sink     item,
    vrtr_result_if.source result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [53:0]   cfg_data
);

    localparam int SW         = $clog2(MAX_SIDE + 1);
    localparam int RESET_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

    logic [SW-1:0]   cols_reg, rows_reg, slcs_reg;
    logic [2*SW-1:0] plane_reg;
    logic [SW-1:0]   side_next;
    xcfg_t           xcfg_reg;
    logic            geo_valid, geo_ready, bl_valid, bl_ready;
    geo_t            geo;
    bl_t             bl;

    always_comb
    begin
        priority if (cfg_data[6:0] < 7'd2)
        begin
            side_next = SW'(2);
        end
        else if (32'(cfg_data[6:0]) > 32'(MAX_SIDE))
        begin
            side_next = SW'(MAX_SIDE);
        end
        else
        begin
            side_next = SW'(cfg_data[6:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg         <= SW'(RESET_SIDE);
            rows_reg         <= SW'(RESET_SIDE);
            slcs_reg         <= SW'(RESET_SIDE);
            plane_reg        <= (2*SW)'(RESET_SIDE * RESET_SIDE);
            xcfg_reg.mrow[0] <= ROW_A_RESET;
            xcfg_reg.mrow[1] <= ROW_B_RESET;
            xcfg_reg.mrow[2] <= ROW_C_RESET;
            xcfg_reg.center  <= '0;
            xcfg_reg.shift   <= '0;
        end
        else
        begin
            plane_reg <= (2*SW)'(cols_reg) * (2*SW)'(rows_reg);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_N_COLS:       cols_reg         <= side_next;
                    CFG_N_ROWS:       rows_reg         <= side_next;
                    CFG_N_SLICES:     slcs_reg         <= side_next;
                    CFG_MATRIX_ROW_A: xcfg_reg.mrow[0] <= cfg_data;
                    CFG_MATRIX_ROW_B: xcfg_reg.mrow[1] <= cfg_data;
                    CFG_MATRIX_ROW_C: xcfg_reg.mrow[2] <= cfg_data;
                    CFG_CENTER:       xcfg_reg.center  <= cfg_data;
                    CFG_SHIFT:        xcfg_reg.shift   <= cfg_data;
                endcase
            end
        end
    end

    vrtr_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (xcfg_reg),
        .geo_valid (geo_valid),
        .geo       (geo),
        .geo_ready (geo_ready)
    );

    vrtr_fetch #(
        .VOXELS   (VOXELS),
        .MAX_SIDE (MAX_SIDE)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .geo_valid (geo_valid),
        .geo       (geo),
        .geo_ready (geo_ready),
        .cols      (cols_reg),
        .rows      (rows_reg),
        .slcs      (slcs_reg),
        .plane     (plane_reg),
        .bl_valid  (bl_valid),
        .bl        (bl),
        .bl_ready  (bl_ready)
    );

    vrtr_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .bl_valid (bl_valid),
        .bl       (bl),
        .bl_ready (bl_ready),
        .result   (result)
    );

endmodule

// ----- verif/volume_rigid_trilinear_resample_tb.sv -----
// ----------------------------------------------------------------------------
// volume_rigid_trilinear_resample_tb
// Self-checking bench for the rigid-transform trilinear resampler. Loads fill
// a shadow volume, queries are scored against an in-bench interpolator, and
// the configuration moves through small, extreme and random settings.
// ----------------------------------------------------------------------------
module volume_rigid_trilinear_resample_tb;
    import vrtr_pkg::*;

    typedef struct {
        logic        action;
        logic [17:0] addr;
        logic [15:0] val;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [5:0]  slc;
        bit          typed;
        logic [15:0] t_val;
        logic        t_inr;
    } stim_t;

    typedef struct {
        logic [15:0] val;
        logic        inr;
    } voxel_res_t;

    localparam int RANDOM_ITEMS = 1750;
    localparam int WATCHDOG     = 5000;
    localparam int SETTLE       = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [53:0] cfg_data;

    vrtr_item_if   item_ch ();
    vrtr_result_if res_ch ();

    volume_rigid_trilinear_resample dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [15:0] vox_mem [0:262143];
    bit          vox_written [0:262143];
    logic [6:0]  side_reg [3];
    logic [53:0] mrow [3];
    logic [53:0] center_reg;
    logic [53:0] shift_reg;

    stim_t      offered_items[$];
    voxel_res_t expected_voxels[$];
    stim_t      dir_tab[$];

    int errors;
    int stalled_cycles;
    int src_idle;
    int rcv_idle;
    int hold_left;
    bit hold_req;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint coef(logic [53:0] w, int pos);
        logic signed [17:0] f;
        f = w[18*pos +: 18];
        return longint'(f);
    endfunction

    function automatic longint side_of(logic [6:0] v);
        if (v < 2)
            return 2;
        if (v > 64)
            return 64;
        return longint'(v);
    endfunction

    function automatic voxel_res_t sample_volume(logic [5:0] r, logic [5:0] c,
                                                 logic [5:0] s);
        longint     idx [3];
        longint     p [3];
        longint     base [3];
        longint     w1 [3];
        longint     w0 [3];
        longint     x;
        longint     t;
        longint     frac;
        longint     cols;
        longint     rows;
        longint     slcs;
        longint     a;
        logic [63:0] acc;
        logic [63:0] wp;
        logic [63:0] v;
        voxel_res_t o;
        idx[0] = r;
        idx[1] = c;
        idx[2] = s;
        for (int k = 0; k < 3; k++)
            p[k] = idx[k] * 256 - coef(center_reg, k) + 128 - coef(shift_reg, k);
        for (int m = 0; m < 3; m++)
        begin
            x = coef(center_reg, m) * 65536;
            for (int k = 0; k < 3; k++)
                x += coef(mrow[m], k) * p[k];
            t = x - (64'sd1 <<< 23);
            base[m] = t >>> 24;
            frac = t - (base[m] <<< 24);
            w1[m] = (frac + 128) >>> 8;
            w0[m] = 65536 - w1[m];
        end
        cols = side_of(side_reg[0]);
        rows = side_of(side_reg[1]);
        slcs = side_of(side_reg[2]);
        o.val = '0;
        o.inr = 1'b0;
        if (base[0] < 0 || base[0] >= rows - 1 || base[1] < 0 || base[1] >= cols - 1 ||
            base[2] < 0 || base[2] >= slcs - 1)
            return o;
        acc = '0;
        for (int n = 0; n < 8; n++)
        begin
            a = (base[1] + n[1]) + cols * (base[0] + n[0]) + cols * rows * (base[2] + n[2]);
            wp = (n[0] ? w1[0] : w0[0]) * (n[1] ? w1[1] : w0[1]) * (n[2] ? w1[2] : w0[2]);
            acc += 64'(vox_mem[a]) * wp;
        end
        v = (acc + (64'd1 << 47)) >> 48;
        o.val = (v > 65535) ? 16'hFFFF : v[15:0];
        o.inr = 1'b1;
        return o;
    endfunction

    function automatic stim_t mk(logic act, int addr, int val, int r, int c, int s,
                                 bit typed = 0, int tv = 0, logic ti = 0);
        stim_t x;
        x.action = act;
        x.addr   = addr[17:0];
        x.val    = val[15:0];
        x.row    = r[5:0];
        x.col    = c[5:0];
        x.slc    = s[5:0];
        x.typed  = typed;
        x.t_val  = tv[15:0];
        x.t_inr  = ti;
        return x;
    endfunction

    // Drive one transaction and hold it until accepted.
    task automatic offer(stim_t s);
        while ($urandom_range(99) < src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        if (s.action == ACT_LOAD)
            vox_written[s.addr] = 1'b1;
        offered_items.push_back(s);
        item_ch.valid         <= 1'b1;
        item_ch.action        <= s.action;
        item_ch.voxel_address <= s.addr;
        item_ch.voxel_value   <= s.val;
        item_ch.out_row       <= s.row;
        item_ch.out_col       <= s.col;
        item_ch.out_slice     <= s.slc;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        while (offered_items.size() != 0 || expected_voxels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [53:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            CFG_N_COLS:       side_reg[0] = d[6:0];
            CFG_N_ROWS:       side_reg[1] = d[6:0];
            CFG_N_SLICES:     side_reg[2] = d[6:0];
            CFG_MATRIX_ROW_A: mrow[0] = d;
            CFG_MATRIX_ROW_B: mrow[1] = d;
            CFG_MATRIX_ROW_C: mrow[2] = d;
            CFG_CENTER:       center_reg = d;
            CFG_SHIFT:        shift_reg = d;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [17:0] q18(int v);
        return v[17:0];
    endfunction

    function automatic logic [17:0] rand_coef();
        case ($urandom_range(3))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            default: return 18'($urandom);
        endcase
    endfunction

    // Pick and write one full setting; returns nothing, updates the shadow copy.
    task automatic apply_setting(int variant);
        logic [6:0]  sz [3];
        logic [53:0] m [3];
        logic [53:0] ctr;
        logic [53:0] sft;
        int          d;
        for (int k = 0; k < 3; k++)
            sz[k] = 7'($urandom_range(2, 6));
        case (variant)
            3:
            begin
                sz[0] = 7'd2;
                sz[1] = 7'd2;
                sz[2] = 7'd2;
                sz[$urandom_range(2)] = 7'd64;
            end
            6:
            begin
                sz[0] = 7'd127;
                sz[1] = 7'd1;
                sz[2] = 7'd0;
            end
            default: ;
        endcase
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                if (variant == 4)
                    m[r][18*c +: 18] = rand_coef();
                else if (variant == 5)
                begin
                    d = (r == c) ? $urandom_range(32768, 98304) : $urandom_range(40000) - 20000;
                    m[r][18*c +: 18] = q18(d);
                end
                else
                begin
                    d = $urandom_range(12000) - 6000;
                    m[r][18*c +: 18] = q18((r == c) ? 65536 + d : d);
                end
            end
        if (variant == 4)
        begin
            ctr = 54'({$urandom, $urandom});
            sft = 54'({$urandom, $urandom});
        end
        else
        begin
            ctr[17:0]  = q18($urandom_range(side_of(sz[1]) * 256));
            ctr[35:18] = q18($urandom_range(side_of(sz[0]) * 256));
            ctr[53:36] = q18($urandom_range(side_of(sz[2]) * 256));
            for (int k = 0; k < 3; k++)
                sft[18*k +: 18] = q18($urandom_range(1024) - 512);
        end
        write_reg(CFG_N_COLS, 54'(sz[0]));
        write_reg(CFG_N_ROWS, 54'(sz[1]));
        write_reg(CFG_N_SLICES, 54'(sz[2]));
        write_reg(CFG_MATRIX_ROW_A, m[0]);
        write_reg(CFG_MATRIX_ROW_B, m[1]);
        write_reg(CFG_MATRIX_ROW_C, m[2]);
        write_reg(CFG_CENTER, ctr);
        write_reg(CFG_SHIFT, sft);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_voxel();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sender-side main sequence.
    initial
    begin
        int  n_rand;
        int  region;
        int  variant;
        bit  hold_done;
        stim_t s;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_LOAD;
        item_ch.voxel_address = '0;
        item_ch.voxel_value   = '0;
        item_ch.out_row       = '0;
        item_ch.out_col       = '0;
        item_ch.out_slice     = '0;
        res_ch.ready          = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_N_COLS;
        cfg_data              = '0;
        errors                = 0;
        stalled_cycles        = 0;
        hold_left             = 0;
        hold_req              = 1'b0;
        hold_done             = 1'b0;
        src_idle              = 16;
        rcv_idle              = 58;
        n_rand                = 0;
        variant               = 0;
        side_reg[0]           = 7'd64;
        side_reg[1]           = 7'd64;
        side_reg[2]           = 7'd64;
        mrow[0]               = ROW_A_RESET;
        mrow[1]               = ROW_B_RESET;
        mrow[2]               = ROW_C_RESET;
        center_reg            = '0;
        shift_reg             = '0;
        foreach (vox_written[a])
        begin
            vox_written[a] = 1'b0;
            vox_mem[a]     = '0;
        end

        // Reset setting: identity, 64 cube, so a query lands on one voxel.
        dir_tab.push_back(mk(ACT_LOAD, 0, 16'hFFFF, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 1, 16'h0000, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 64, 16'h5A5A, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 65, 16'hA5A5, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 4096, 16'h0001, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 4097, 16'h8000, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 4160, 16'h7FFF, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 4161, 16'h1234, 0, 0, 0));
        dir_tab.push_back(mk(ACT_LOAD, 262143, 16'hFFFF, 0, 0, 0));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 1, 16'hFFFF, 1'b1));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 63, 63, 63, 1, 0, 1'b0));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 63, 0, 0, 1, 0, 1'b0));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 0, 63, 0, 1, 0, 1'b0));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 63, 1, 0, 1'b0));
        dir_tab.push_back(mk(ACT_LOAD, 0, 16'h0000, 0, 0, 0));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 1, 16'h0000, 1'b1));
        dir_tab.push_back(mk(ACT_LOAD, 0, 16'hC3C3, 0, 0, 0));
        dir_tab.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0));

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            offer(dir_tab[i]);

        while (n_rand < RANDOM_ITEMS)
        begin
            item_ch.valid <= 1'b0;
            drain();
            apply_setting(variant % 7);
            variant++;
            region = side_of(side_reg[0]) * side_of(side_reg[1]) * side_of(side_reg[2]);
            for (int a = 0; a < region; a++)
                if (!vox_written[a])
                begin
                    offer(mk(ACT_LOAD, a, rand_voxel(), 0, 0, 0));
                    n_rand++;
                end
            for (int k = 0; k < 110 && n_rand < RANDOM_ITEMS; k++)
            begin
                if (n_rand < RANDOM_ITEMS / 3)
                begin
                    src_idle = 16;
                    rcv_idle = 58;
                end
                else if (n_rand < 2 * RANDOM_ITEMS / 3)
                begin
                    src_idle = 58;
                    rcv_idle = 16;
                end
                else
                begin
                    src_idle = 0;
                    rcv_idle = 0;
                    if (!hold_done)
                    begin
                        hold_req  = 1'b1;
                        hold_done = 1'b1;
                    end
                end
                if ($urandom_range(99) < 35)
                begin
                    if ($urandom_range(9) == 0)
                        s = mk(ACT_LOAD, $urandom, rand_voxel(), 0, 0, 0);
                    else
                        s = mk(ACT_LOAD, $urandom_range(region - 1), rand_voxel(), 0, 0, 0);
                    s.row = 6'($urandom);
                    s.col = 6'($urandom);
                    s.slc = 6'($urandom);
                end
                else if ($urandom_range(9) < 8)
                    s = mk(ACT_QUERY, $urandom, $urandom,
                           $urandom_range(side_of(side_reg[1])),
                           $urandom_range(side_of(side_reg[0])),
                           $urandom_range(side_of(side_reg[2])));
                else
                    s = mk(ACT_QUERY, $urandom, $urandom, $urandom_range(63),
                           $urandom_range(63), $urandom_range(63));
                offer(s);
                n_rand++;
            end
        end
        item_ch.valid <= 1'b0;
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result-side ready, with one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 300;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        stim_t      acc_item;
        voxel_res_t want;
        if (rst_n)
        begin
            stalled_cycles = stalled_cycles + 1;
            if (item_ch.valid && item_ch.ready)
            begin
                stalled_cycles = 0;
                acc_item = offered_items.pop_front();
                if (acc_item.action == ACT_LOAD)
                    vox_mem[acc_item.addr] = acc_item.val;
                else if (acc_item.typed)
                begin
                    want.val = acc_item.t_val;
                    want.inr = acc_item.t_inr;
                    expected_voxels.push_back(want);
                end
                else
                    expected_voxels.push_back(sample_volume(acc_item.row, acc_item.col,
                                                            acc_item.slc));
            end
            if (res_ch.valid && res_ch.ready)
            begin
                stalled_cycles = 0;
                if (expected_voxels.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result out_value %h in_range %b", $time,
                             res_ch.out_value, res_ch.in_range);
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    if (res_ch.out_value !== want.val)
                    begin
                        errors++;
                        $display("%0t: out_value expected %h got %h", $time, want.val,
                                 res_ch.out_value);
                    end
                    if (res_ch.in_range !== want.inr)
                    begin
                        errors++;
                        $display("%0t: in_range expected %b got %b", $time, want.inr,
                                 res_ch.in_range);
                    end
                end
            end
            if (stalled_cycles >= WATCHDOG)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
